// ----- rtl/lur_pkg.sv -----
// ----------------------------------------------------------------------------
// lur_pkg
// Shared types and constants for the lens undistortion remap address block.
// ----------------------------------------------------------------------------
package lur_pkg;

    // Image size defaults for the top-level parameters
    localparam int IMAGE_WIDTH_DEF  = 1024;
    localparam int IMAGE_HEIGHT_DEF = 1024;

    // Configuration port
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_P1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_P2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y      = 3'd7;

    // Register reset values
    localparam logic [19:0] K1_RST = 20'hE1C6A;
    localparam logic [19:0] K2_RST = 20'h10000;
    localparam logic [19:0] P1_RST = 20'hFC333;
    localparam logic [19:0] P2_RST = 20'h00000;
    localparam logic [19:0] FX_RST = 20'h1CAA7;
    localparam logic [19:0] FY_RST = 20'h1CAA7;
    localparam logic [20:0] CX_RST = 21'h08600;
    localparam logic [20:0] CY_RST = 21'h16800;

    // Normalising divider: one quotient bit per stage
    localparam int DIV_BITS = 20;
    localparam int REM_W    = 40;

    // Distortion pipeline depth, output register included
    localparam int POLY_STAGES = 10;

    // Register stages from input transfer to output register, which is also
    // the number of items the pipeline holds when full
    localparam int LATENCY = DIV_BITS + 1 + POLY_STAGES;

    typedef struct packed {
        logic [19:0] k1;
        logic [19:0] k2;
        logic [19:0] p1;
        logic [19:0] p2;
        logic [19:0] fx;
        logic [19:0] fy;
        logic [20:0] cx;
        logic [20:0] cy;
    } cfg_t;

    // Magnitudes of the normalised coordinates and their signs
    typedef struct packed {
        logic [DIV_BITS-1:0] qx;
        logic [DIV_BITS-1:0] qy;
        logic                neg_x;
        logic                neg_y;
        logic                bad;
    } div_res_t;

endpackage

// ----- rtl/lens_undistort_remap_address_top.sv -----
// ----------------------------------------------------------------------------
// lens_undistort_remap_address_top
// Brown-Conrady undistortion remap address generator, top level.
// ----------------------------------------------------------------------------
// Takes one output pixel coordinate per clock unless in_stall is high and
// returns the floored source coordinate in the distorted image, with in_range
// low (and zero coordinates) where the source falls outside the image or the
// arithmetic overflows. The block is fully pipelined: a new coordinate is
// taken every cycle unless stalled, and each result passes 31 register
// stages: 21 in the restoring divider that normalises by the focal lengths
// (an entry register, then one quotient bit a stage) and 10 in the multiplier
// stages of the distortion polynomial and the output register. A stall holds
// the pipeline but empty stages still fill. Configuration must be written
// only while no coordinate is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module lens_undistort_remap_address_top #(
    parameter int IMAGE_WIDTH  = lur_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = lur_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [lur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lur_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [9:0]                     out_col,
    input  logic [9:0]                     out_row,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [9:0]                     src_col,
    output logic [9:0]                     src_row,
    output logic                           in_range
);

    lur_pkg::cfg_t     cfg_reg;
    lur_pkg::div_res_t div_res;
    logic              div_valid;
    logic              div_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.k1 <= lur_pkg::K1_RST;
            cfg_reg.k2 <= lur_pkg::K2_RST;
            cfg_reg.p1 <= lur_pkg::P1_RST;
            cfg_reg.p2 <= lur_pkg::P2_RST;
            cfg_reg.fx <= lur_pkg::FX_RST;
            cfg_reg.fy <= lur_pkg::FY_RST;
            cfg_reg.cx <= lur_pkg::CX_RST;
            cfg_reg.cy <= lur_pkg::CY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lur_pkg::REG_RADIAL_K1:     cfg_reg.k1 <= cfg_data[19:0];
                lur_pkg::REG_RADIAL_K2:     cfg_reg.k2 <= cfg_data[19:0];
                lur_pkg::REG_TANGENTIAL_P1: cfg_reg.p1 <= cfg_data[19:0];
                lur_pkg::REG_TANGENTIAL_P2: cfg_reg.p2 <= cfg_data[19:0];
                lur_pkg::REG_FOCAL_X:       cfg_reg.fx <= cfg_data[19:0];
                lur_pkg::REG_FOCAL_Y:       cfg_reg.fy <= cfg_data[19:0];
                lur_pkg::REG_CENTER_X:      cfg_reg.cx <= cfg_data;
                lur_pkg::REG_CENTER_Y:      cfg_reg.cy <= cfg_data;
                default:                    cfg_reg.cy <= cfg_reg.cy;
            endcase
        end
    end

    // Normalisation
    lur_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_col   (out_col),
        .out_row   (out_row),
        .cfg       (cfg_reg),
        .res_valid (div_valid),
        .res_stall (div_stall),
        .res       (div_res)
    );

    // Distortion and projection
    lur_poly #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .din_valid (div_valid),
        .din_stall (div_stall),
        .din       (div_res),
        .cfg       (cfg_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .src_col   (src_col),
        .src_row   (src_row),
        .in_range  (in_range)
    );

endmodule

// ----- rtl/lur_div.sv -----
// ----------------------------------------------------------------------------
// lur_div
// Pipelined restoring divider: normalises (col, row) by the principal point
// and the focal lengths, one quotient bit per stage, both axes side by side.
// ----------------------------------------------------------------------------
module lur_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [9:0]             out_col,
    input  logic [9:0]             out_row,
    input  lur_pkg::cfg_t          cfg,
    output logic                   res_valid,
    input  logic                   res_stall,
    output lur_pkg::div_res_t      res
);

    localparam int NB = lur_pkg::DIV_BITS;
    localparam int RW = lur_pkg::REM_W;

    logic [NB:0]   vld_reg;
    logic [NB+1:0] rdy;

    logic [RW-1:0] remx_reg [0:NB];
    logic [RW-1:0] remy_reg [0:NB];
    logic [NB-1:0] qx_reg   [0:NB];
    logic [NB-1:0] qy_reg   [0:NB];
    logic [NB:0]   negx_reg;
    logic [NB:0]   negy_reg;
    logic [NB:0]   bad_reg;

    logic signed [21:0] dx;
    logic signed [21:0] dy;
    logic [20:0]        adx;
    logic [20:0]        ady;
    logic               ovf_x;
    logic               ovf_y;

    logic [RW-1:0] dvx      [1:NB];
    logic [RW-1:0] dvy      [1:NB];
    logic [NB:1]   gex;
    logic [NB:1]   gey;
    logic [RW-1:0] remx_next [1:NB];
    logic [RW-1:0] remy_next [1:NB];
    logic [NB-1:0] qx_next   [1:NB];
    logic [NB-1:0] qy_next   [1:NB];

    // Stall chain: a stage takes data when empty or when it moves on
    always_comb
    begin
        rdy[NB+1] = !res_stall;
        for (int s = NB; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    assign in_stall = !rdy[0];

    // Entry: offset from principal point, magnitude, overflow
    // |q| >= 2^20 exactly when |d| >= 16 * focal; zero focal lands here too
    always_comb
    begin
        dx    = $signed({4'b0, out_col, 8'b0}) - $signed({cfg.cx[20], cfg.cx});
        dy    = $signed({4'b0, out_row, 8'b0}) - $signed({cfg.cy[20], cfg.cy});
        adx   = dx[21] ? 21'(-dx) : dx[20:0];
        ady   = dy[21] ? 21'(-dy) : dy[20:0];
        ovf_x = {3'b0, adx} >= {cfg.fx, 4'b0};
        ovf_y = {3'b0, ady} >= {cfg.fy, 4'b0};
    end

    // One quotient bit per stage, most significant first
    always_comb
    begin
        for (int s = 1; s <= NB; s++)
        begin
            dvx[s] = RW'(cfg.fx) << (NB - s);
            dvy[s] = RW'(cfg.fy) << (NB - s);
            gex[s] = remx_reg[s-1] >= dvx[s];
            gey[s] = remy_reg[s-1] >= dvy[s];
            remx_next[s] = gex[s] ? remx_reg[s-1] - dvx[s] : remx_reg[s-1];
            remy_next[s] = gey[s] ? remy_reg[s-1] - dvy[s] : remy_reg[s-1];
            qx_next[s] = qx_reg[s-1] | (NB'(gex[s]) << (NB - s));
            qy_next[s] = qy_reg[s-1] | (NB'(gey[s]) << (NB - s));
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int s = 1; s <= NB; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            remx_reg[0] <= {3'b0, adx, 16'b0};
            remy_reg[0] <= {3'b0, ady, 16'b0};
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            negx_reg[0] <= dx[21];
            negy_reg[0] <= dy[21];
            bad_reg[0]  <= ovf_x || ovf_y;
        end
        for (int s = 1; s <= NB; s++)
        begin
            if (rdy[s])
            begin
                remx_reg[s] <= remx_next[s];
                remy_reg[s] <= remy_next[s];
                qx_reg[s]   <= qx_next[s];
                qy_reg[s]   <= qy_next[s];
                negx_reg[s] <= negx_reg[s-1];
                negy_reg[s] <= negy_reg[s-1];
                bad_reg[s]  <= bad_reg[s-1];
            end
        end
    end

    assign res_valid = vld_reg[NB];
    assign res.qx    = qx_reg[NB];
    assign res.qy    = qy_reg[NB];
    assign res.neg_x = negx_reg[NB];
    assign res.neg_y = negy_reg[NB];
    assign res.bad   = bad_reg[NB];

endmodule

// ----- rtl/lur_poly.sv -----
// ----------------------------------------------------------------------------
// lur_poly
// Distortion pipeline: r^2, radial and tangential terms, projection back to
// pixels, range check and output register.
// ----------------------------------------------------------------------------
module lur_poly #(
    parameter int IMAGE_WIDTH  = lur_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = lur_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              din_valid,
    output logic              din_stall,
    input  lur_pkg::div_res_t din,
    input  lur_pkg::cfg_t     cfg,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [9:0]        src_col,
    output logic [9:0]        src_row,
    output logic              in_range
);

    localparam int NP = lur_pkg::POLY_STAGES;

    localparam logic signed [55:0] RAD_ONE = 56'sh1_0000_0000;

    logic [NP-1:0] vld_reg;
    logic [NP:0]   rdy;

    // Stall chain
    always_comb
    begin
        rdy[NP] = !out_stall;
        for (int s = NP - 1; s >= 0; s--)
        begin
            rdy[s] = !vld_reg[s] || rdy[s+1];
        end
    end

    assign din_stall = !rdy[0];
    assign out_valid = vld_reg[NP-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= din_valid;
            end
            for (int s = 1; s < NP; s++)
            begin
                if (rdy[s])
                begin
                    vld_reg[s] <= vld_reg[s-1];
                end
            end
        end
    end

    // Signed normalised coordinates, Q16
    logic signed [20:0] x_in;
    logic signed [20:0] y_in;

    assign x_in = din.neg_x ? -$signed({1'b0, din.qx}) : $signed({1'b0, din.qx});
    assign y_in = din.neg_y ? -$signed({1'b0, din.qy}) : $signed({1'b0, din.qy});

    // Stage 1: squares and cross product
    logic signed [20:0] x1_reg, y1_reg;
    logic signed [41:0] xx_next, yy_next;
    logic signed [40:0] xyp_next;
    logic [39:0]        xx1_reg, yy1_reg;
    logic signed [40:0] xyp1_reg;
    logic               bad1_reg;

    assign xx_next  = x_in * x_in;
    assign yy_next  = y_in * y_in;
    assign xyp_next = x_in * y_in;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            x1_reg   <= x_in;
            y1_reg   <= y_in;
            xx1_reg  <= xx_next[39:0];
            yy1_reg  <= yy_next[39:0];
            xyp1_reg <= xyp_next;
            bad1_reg <= din.bad;
        end
    end

    // Stage 2: r^2, xy and r^2 + 2x^2, r^2 + 2y^2
    logic [40:0]        rsum;
    logic [24:0]        r2_next;
    logic [24:0]        r2_2_reg;
    logic signed [24:0] xy2_reg;
    logic [25:0]        ax2_reg, ay2_reg;
    logic signed [20:0] x2_reg, y2_reg;
    logic               bad2_reg;

    assign rsum    = {1'b0, xx1_reg} + {1'b0, yy1_reg};
    assign r2_next = rsum[40:16];

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            r2_2_reg <= r2_next;
            xy2_reg  <= xyp1_reg[40:16];
            ax2_reg  <= {1'b0, r2_next} + {1'b0, xx1_reg[39:15]};
            ay2_reg  <= {1'b0, r2_next} + {1'b0, yy1_reg[39:15]};
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            bad2_reg <= bad1_reg;
        end
    end

    // Stage 3: coefficient products and the square of r^2
    logic [49:0]        r2sq3_reg;
    logic signed [45:0] k1r2_3_reg;
    logic signed [44:0] p1xy3_reg, p2xy3_reg;
    logic signed [46:0] p2ax3_reg, p1ay3_reg;
    logic signed [20:0] x3_reg, y3_reg;
    logic               bad3_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            r2sq3_reg  <= r2_2_reg * r2_2_reg;
            k1r2_3_reg <= $signed(cfg.k1) * $signed({1'b0, r2_2_reg});
            p1xy3_reg  <= $signed(cfg.p1) * xy2_reg;
            p2xy3_reg  <= $signed(cfg.p2) * xy2_reg;
            p2ax3_reg  <= $signed(cfg.p2) * $signed({1'b0, ax2_reg});
            p1ay3_reg  <= $signed(cfg.p1) * $signed({1'b0, ay2_reg});
            x3_reg     <= x2_reg;
            y3_reg     <= y2_reg;
            bad3_reg   <= bad2_reg;
        end
    end

    // Stage 4: r^4
    logic [33:0]        r4_4_reg;
    logic signed [45:0] k1r2_4_reg;
    logic signed [44:0] p1xy4_reg, p2xy4_reg;
    logic signed [46:0] p2ax4_reg, p1ay4_reg;
    logic signed [20:0] x4_reg, y4_reg;
    logic               bad4_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            r4_4_reg   <= r2sq3_reg[49:16];
            k1r2_4_reg <= k1r2_3_reg;
            p1xy4_reg  <= p1xy3_reg;
            p2xy4_reg  <= p2xy3_reg;
            p2ax4_reg  <= p2ax3_reg;
            p1ay4_reg  <= p1ay3_reg;
            x4_reg     <= x3_reg;
            y4_reg     <= y3_reg;
            bad4_reg   <= bad3_reg;
        end
    end

    // Stage 5: k2 * r^4
    logic signed [54:0] k2r4_5_reg;
    logic signed [45:0] k1r2_5_reg;
    logic signed [44:0] p1xy5_reg, p2xy5_reg;
    logic signed [46:0] p2ax5_reg, p1ay5_reg;
    logic signed [20:0] x5_reg, y5_reg;
    logic               bad5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            k2r4_5_reg <= $signed(cfg.k2) * $signed({1'b0, r4_4_reg});
            k1r2_5_reg <= k1r2_4_reg;
            p1xy5_reg  <= p1xy4_reg;
            p2xy5_reg  <= p2xy4_reg;
            p2ax5_reg  <= p2ax4_reg;
            p1ay5_reg  <= p1ay4_reg;
            x5_reg     <= x4_reg;
            y5_reg     <= y4_reg;
            bad5_reg   <= bad4_reg;
        end
    end

    // Stage 6: radial factor and tangential sums
    logic signed [55:0] rad_sum;
    logic signed [39:0] rad6_reg;
    logic signed [47:0] tx6_reg, ty6_reg;
    logic signed [20:0] x6_reg, y6_reg;
    logic               bad6_reg;

    assign rad_sum = RAD_ONE + k1r2_5_reg + k2r4_5_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[5])
        begin
            rad6_reg <= rad_sum[55:16];
            tx6_reg  <= $signed({p1xy5_reg, 1'b0}) + p2ax5_reg;
            ty6_reg  <= p1ay5_reg + $signed({p2xy5_reg, 1'b0});
            x6_reg   <= x5_reg;
            y6_reg   <= y5_reg;
            bad6_reg <= bad5_reg;
        end
    end

    // Stage 7: x * rad, y * rad
    logic signed [60:0] xrad7_reg, yrad7_reg;
    logic signed [47:0] tx7_reg, ty7_reg;
    logic               bad7_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[6])
        begin
            xrad7_reg <= x6_reg * rad6_reg;
            yrad7_reg <= y6_reg * rad6_reg;
            tx7_reg   <= tx6_reg;
            ty7_reg   <= ty6_reg;
            bad7_reg  <= bad6_reg;
        end
    end

    // Stage 8: distorted coordinates and their overflow check
    logic signed [61:0] sx, sy;
    logic signed [45:0] xd, yd;
    logic               xd_ok, yd_ok;
    logic signed [40:0] xd8_reg, yd8_reg;
    logic               bad8_reg;

    always_comb
    begin
        sx    = xrad7_reg + tx7_reg;
        sy    = yrad7_reg + ty7_reg;
        xd    = sx[61:16];
        yd    = sy[61:16];
        // inside the open interval (-2^40, 2^40)
        xd_ok = (xd[45:40] == 6'h00) || (xd[45:40] == 6'h3F && xd[39:0] != 40'd0);
        yd_ok = (yd[45:40] == 6'h00) || (yd[45:40] == 6'h3F && yd[39:0] != 40'd0);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[7])
        begin
            xd8_reg  <= xd[40:0];
            yd8_reg  <= yd[40:0];
            bad8_reg <= bad7_reg || !xd_ok || !yd_ok;
        end
    end

    // Stage 9: focal length products
    logic signed [61:0] mx9_reg, my9_reg;
    logic               bad9_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[8])
        begin
            mx9_reg  <= $signed({1'b0, cfg.fx}) * xd8_reg;
            my9_reg  <= $signed({1'b0, cfg.fy}) * yd8_reg;
            bad9_reg <= bad8_reg;
        end
    end

    // Stage 10: add principal point, floor, range check, output register
    logic signed [62:0] csum, rsum_pix;
    logic signed [38:0] col, row;
    logic               ok;
    logic [9:0]         src_col_reg, src_row_reg;
    logic               in_range_reg;

    always_comb
    begin
        csum     = mx9_reg + $signed({cfg.cx, 16'b0});
        rsum_pix = my9_reg + $signed({cfg.cy, 16'b0});
        col      = csum[62:24];
        row      = rsum_pix[62:24];
        ok       = !bad9_reg && !col[38] && !row[38]
                   && (col[37:0] < 38'(IMAGE_WIDTH))
                   && (row[37:0] < 38'(IMAGE_HEIGHT));
    end

    always_ff @(posedge clk)
    begin
        if (rdy[9])
        begin
            src_col_reg  <= ok ? col[9:0] : 10'd0;
            src_row_reg  <= ok ? row[9:0] : 10'd0;
            in_range_reg <= ok;
        end
    end

    assign src_col  = src_col_reg;
    assign src_row  = src_row_reg;
    assign in_range = in_range_reg;

endmodule

// ----- rtl/lur_chk.sv -----
// ----------------------------------------------------------------------------
// lur_chk
// Port-level checks for the remap address block, bound to the top level.
// ----------------------------------------------------------------------------
module lur_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [9:0] src_col,
    input logic [9:0] src_row,
    input logic       in_range
);

    localparam int FULL = lur_pkg::LATENCY;

    // Items in flight: transfers in minus transfers out
    logic [5:0] cnt_reg;
    logic [5:0] cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_valid && !in_stall && !(out_valid && !out_stall))
        begin
            cnt_next = cnt_reg + 6'd1;
        end
        else if (!(in_valid && !in_stall) && out_valid && !out_stall)
        begin
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // No result without an item in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 6'd0 |-> !out_valid)
        else $error("result shown with nothing in flight");

    // Input is held back only when every stage is occupied
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 6'(FULL) |-> !in_stall)
        else $error("input stalled with room in the pipeline");

    // Out-of-range results carry zero coordinates
    a_zero_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> src_col == 10'd0 && src_row == 10'd0)
        else $error("non-zero coordinate on out-of-range result");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(src_col)
            && $stable(src_row) && $stable(in_range))
        else $error("stalled result changed");

endmodule

bind lens_undistort_remap_address_top lur_chk u_lur_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .src_col   (src_col),
    .src_row   (src_row),
    .in_range  (in_range)
);
